// ----- rtl/core/grgb_pkg.sv -----
package grgb_pkg;

  // default glyph geometry
  localparam int GLYPH_ROWS_DEF  = 16;
  localparam int GLYPH_WIDTH_DEF = 8;

  // panel command bytes
  localparam logic [7:0] CMD_COLUMN = 8'h15;
  localparam logic [7:0] CMD_ROW    = 8'h75;
  localparam logic [7:0] CMD_WRITE  = 8'h5C;

  // header word positions
  localparam logic [2:0] HDR_COL_CMD   = 3'd0;
  localparam logic [2:0] HDR_COL_START = 3'd1;
  localparam logic [2:0] HDR_COL_END   = 3'd2;
  localparam logic [2:0] HDR_ROW_CMD   = 3'd3;
  localparam logic [2:0] HDR_ROW_START = 3'd4;
  localparam logic [2:0] HDR_ROW_END   = 3'd5;
  localparam logic [2:0] HDR_WRITE_CMD = 3'd6;

  // one classified row, handed from front to back
  typedef struct packed {
    logic [7:0]  bits;
    logic        header;
    logic        dbl;
    logic [15:0] colour;
    logic [7:0]  scol;
    logic [7:0]  ecol;
    logic [7:0]  srow;
    logic [7:0]  erow;
  } desc_t;

endpackage

// ----- rtl/core/grgb_front.sv -----
module grgb_front #(
  parameter int GLYPH_ROWS  = grgb_pkg::GLYPH_ROWS_DEF,
  parameter int GLYPH_WIDTH = grgb_pkg::GLYPH_WIDTH_DEF
) (
  input  logic [7:0]     in_row_bits,
  input  logic [3:0]     in_row_number,
  input  logic [7:0]     in_start_col,
  input  logic [7:0]     in_start_row,
  input  logic [4:0]     in_red,
  input  logic [5:0]     in_green,
  input  logic [4:0]     in_blue,
  input  logic           in_double_size,
  output grgb_pkg::desc_t desc
);
  import grgb_pkg::*;

  localparam logic [7:0] COL_SPAN1 = 8'(GLYPH_WIDTH - 1);
  localparam logic [7:0] COL_SPAN2 = 8'(2 * GLYPH_WIDTH - 1);
  localparam logic [7:0] ROW_SPAN1 = 8'(GLYPH_ROWS - 1);
  localparam logic [7:0] ROW_SPAN2 = 8'(2 * GLYPH_ROWS - 1);

  // classify the row: header on row 0, window ends wrap mod 256
  always_comb begin
    desc.bits   = in_row_bits;
    desc.header = (in_row_number == 4'd0);
    desc.dbl    = in_double_size;
    desc.colour = {in_red, in_green, in_blue};
    desc.scol   = in_start_col;
    desc.srow   = in_start_row;
    desc.ecol   = in_start_col + (in_double_size ? COL_SPAN2 : COL_SPAN1);
    desc.erow   = in_start_row + (in_double_size ? ROW_SPAN2 : ROW_SPAN1);
  end

endmodule

// ----- rtl/core/grgb_queue.sv -----
module grgb_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  grgb_pkg::desc_t din,
  output logic            full,
  input  logic            pop,
  output grgb_pkg::desc_t dout,
  output logic            nonempty
);
  import grgb_pkg::*;

  desc_t      mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;

  assign full     = (count_r == 2'd2);
  assign nonempty = (count_r != 2'd0);
  assign dout     = mem_r[rd_ptr_r];

  // two-entry descriptor queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      if (push && !pop)      count_r <= count_r + 2'd1;
      else if (pop && !push) count_r <= count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= din;
  end

endmodule

// ----- rtl/core/grgb_back.sv -----
module grgb_back #(
  parameter int GLYPH_WIDTH = grgb_pkg::GLYPH_WIDTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_nonempty,
  input  grgb_pkg::desc_t q_desc,
  output logic            q_pop,
  output logic            out_empty,
  input  logic            out_pop,
  output logic [15:0]     out_word,
  output logic            out_is_pixel,
  output logic            out_is_data,
  output logic            out_last
);
  import grgb_pkg::*;

  localparam int JW = (GLYPH_WIDTH > 1) ? $clog2(GLYPH_WIDTH) : 1;
  localparam logic [JW-1:0] J_TOP = JW'(GLYPH_WIDTH - 1);

  desc_t         desc_r;
  logic          busy_r;
  logic          hdr_r;
  logic [2:0]    hidx_r;
  logic [JW-1:0] j_r;
  logic          rep_r, line_r;
  logic          out_valid_r;

  logic        emit, last_word, pix_set, load;
  logic [4:0]  j_ext;
  logic [15:0] word_nxt;
  logic        is_pixel_nxt, is_data_nxt;

  assign out_empty = !out_valid_r;
  assign emit      = busy_r && (!out_valid_r || out_pop);

  // current word
  assign j_ext   = 5'(j_r);
  assign pix_set = (j_ext < 5'd8) && desc_r.bits[j_ext[2:0]];
  assign last_word = !hdr_r && (j_r == '0) && (rep_r == desc_r.dbl) &&
                     (line_r == desc_r.dbl);

  always_comb begin
    word_nxt     = 16'd0;
    is_pixel_nxt = 1'b0;
    is_data_nxt  = 1'b1;
    if (hdr_r) begin
      case (hidx_r)
        HDR_COL_CMD:   begin word_nxt = {8'd0, CMD_COLUMN}; is_data_nxt = 1'b0; end
        HDR_COL_START: word_nxt = {8'd0, desc_r.scol};
        HDR_COL_END:   word_nxt = {8'd0, desc_r.ecol};
        HDR_ROW_CMD:   begin word_nxt = {8'd0, CMD_ROW}; is_data_nxt = 1'b0; end
        HDR_ROW_START: word_nxt = {8'd0, desc_r.srow};
        HDR_ROW_END:   word_nxt = {8'd0, desc_r.erow};
        HDR_WRITE_CMD: begin word_nxt = {8'd0, CMD_WRITE}; is_data_nxt = 1'b0; end
        default:       word_nxt = 16'd0;
      endcase
    end else begin
      word_nxt     = pix_set ? desc_r.colour : 16'd0;
      is_pixel_nxt = 1'b1;
    end
  end

  // take the next descriptor when idle or on the final word of this row
  assign load  = q_nonempty && (!busy_r || (emit && last_word));
  assign q_pop = load;

  // word sequencer: header, then line / bit / repeat counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (load) begin
      busy_r <= 1'b1;
    end else if (emit && last_word) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      desc_r <= q_desc;
      hdr_r  <= q_desc.header;
      hidx_r <= HDR_COL_CMD;
      j_r    <= J_TOP;
      rep_r  <= 1'b0;
      line_r <= 1'b0;
    end else if (emit) begin
      if (hdr_r) begin
        if (hidx_r == HDR_WRITE_CMD) hdr_r <= 1'b0;
        else hidx_r <= hidx_r + 3'd1;
      end else if (desc_r.dbl && !rep_r) begin
        rep_r <= 1'b1;
      end else begin
        rep_r <= 1'b0;
        if (j_r == '0) begin
          j_r    <= J_TOP;
          line_r <= 1'b1;
        end else begin
          j_r <= j_r - JW'(1);
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_word     <= word_nxt;
      out_is_pixel <= is_pixel_nxt;
      out_is_data  <= is_data_nxt;
      out_last     <= last_word;
    end
  end

endmodule

// ----- rtl/core/glyph_row_to_rgb565_stream_unit.sv -----
// Expands one monochrome glyph row into panel words: on row 0 a seven-word
// window set-up (column command, start/end column, row command, start/end
// row, memory-write command), then one RGB565 word per glyph bit, leftmost
// first, zero for clear bits; double size repeats each pixel and the line.
// Words leave at one per cycle from the back-end sequencer while the
// receiver pops; a row gives GLYPH_WIDTH*s*s words (s = 2 in double size,
// else 1) plus 7 on row 0: 8 or 15 for a normal row, 32 or 39 doubled.
// Rows are accepted into a two-entry queue while the previous row is
// still being sent, so rows run back to back with no gap at the output.
module glyph_row_to_rgb565_stream_unit #(
  parameter int GLYPH_ROWS  = grgb_pkg::GLYPH_ROWS_DEF,
  parameter int GLYPH_WIDTH = grgb_pkg::GLYPH_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_row_bits,
  input  logic [3:0]  in_row_number,
  input  logic [7:0]  in_start_col,
  input  logic [7:0]  in_start_row,
  input  logic [4:0]  in_red,
  input  logic [5:0]  in_green,
  input  logic [4:0]  in_blue,
  input  logic        in_double_size,
  output logic        empty,
  input  logic        pop,
  output logic [15:0] out_word,
  output logic        out_is_pixel,
  output logic        out_is_data,
  output logic        out_last
);
  import grgb_pkg::*;

  desc_t front_desc, q_desc;
  logic  q_nonempty, q_pop;

  // front end: classify the row
  grgb_front #(
    .GLYPH_ROWS  (GLYPH_ROWS),
    .GLYPH_WIDTH (GLYPH_WIDTH)
  ) u_front (
    .in_row_bits    (in_row_bits),
    .in_row_number  (in_row_number),
    .in_start_col   (in_start_col),
    .in_start_row   (in_start_row),
    .in_red         (in_red),
    .in_green       (in_green),
    .in_blue        (in_blue),
    .in_double_size (in_double_size),
    .desc           (front_desc)
  );

  // decoupling queue
  grgb_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push && !full),
    .din      (front_desc),
    .full     (full),
    .pop      (q_pop),
    .dout     (q_desc),
    .nonempty (q_nonempty)
  );

  // back end: word sequencer and output register
  grgb_back #(
    .GLYPH_WIDTH (GLYPH_WIDTH)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_nonempty   (q_nonempty),
    .q_desc       (q_desc),
    .q_pop        (q_pop),
    .out_empty    (empty),
    .out_pop      (pop),
    .out_word     (out_word),
    .out_is_pixel (out_is_pixel),
    .out_is_data  (out_is_data),
    .out_last     (out_last)
  );

endmodule

// ----- tb/tb_glyph_row_to_rgb565_stream_unit.sv -----
`timescale 1ns / 100ps

module tb_glyph_row_to_rgb565_stream_unit;
  import grgb_pkg::*;

  localparam int GW             = GLYPH_WIDTH_DEF;
  localparam int GH             = GLYPH_ROWS_DEF;
  localparam int HDR_WORDS      = 7;
  localparam int RANDOM_ROWS    = 385;
  localparam int HOLD_LEN       = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES    = 100;
  localparam int MAX_PRINTS     = 40;

  // one glyph row as offered on the input ports
  typedef struct packed {
    logic [7:0] bits;
    logic [3:0] rown;
    logic [7:0] scol;
    logic [7:0] srow;
    logic [4:0] red;
    logic [5:0] green;
    logic [4:0] blue;
    logic       dbl;
  } glyph_row_t;

  // one panel word as expected on the output ports
  typedef struct packed {
    logic [15:0] word;
    logic        is_pixel;
    logic        is_data;
    logic        last;
  } panel_word_t;

  typedef enum logic [1:0] {RX_FULL_RATE, RX_RANDOM, RX_PERIODIC} rx_mode_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  in_row_bits = '0;
  logic [3:0]  in_row_number = '0;
  logic [7:0]  in_start_col = '0;
  logic [7:0]  in_start_row = '0;
  logic [4:0]  in_red = '0;
  logic [5:0]  in_green = '0;
  logic [4:0]  in_blue = '0;
  logic        in_double_size = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [15:0] out_word;
  logic        out_is_pixel;
  logic        out_is_data;
  logic        out_last;

  panel_word_t expected_words[$];
  int          err_count = 0;
  int          rows_accepted = 0;
  int          rows_header = 0;
  int          rows_double = 0;
  int          words_checked = 0;
  int          idle_run = 0;
  logic        hold_req = 1'b0;
  int          burst_left = 0;

  glyph_row_to_rgb565_stream_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_row_bits    (in_row_bits),
    .in_row_number  (in_row_number),
    .in_start_col   (in_start_col),
    .in_start_row   (in_start_row),
    .in_red         (in_red),
    .in_green       (in_green),
    .in_blue        (in_blue),
    .in_double_size (in_double_size),
    .empty          (empty),
    .pop            (pop),
    .out_word       (out_word),
    .out_is_pixel   (out_is_pixel),
    .out_is_data    (out_is_data),
    .out_last       (out_last)
  );

  always #5 clk = ~clk;

  // expected word stream for one accepted row
  task automatic expand_row(input glyph_row_t r);
    int          scale;
    int          total;
    int          k;
    logic [15:0] colour;
    logic [15:0] px;
    logic [7:0]  ecol;
    logic [7:0]  erow;
    logic [7:0]  hdr[HDR_WORDS];
    logic        hdr_data[HDR_WORDS];
    scale  = r.dbl ? 2 : 1;
    colour = {r.red, r.green, r.blue};
    total  = GW * scale * scale + ((r.rown == 0) ? HDR_WORDS : 0);
    k      = 0;
    if (r.rown == 0) begin
      // end coordinates wrap at 8 bits
      ecol = r.scol + 8'(GW * scale - 1);
      erow = r.srow + 8'(GH * scale - 1);
      hdr[HDR_COL_CMD]   = CMD_COLUMN;  hdr_data[HDR_COL_CMD]   = 1'b0;
      hdr[HDR_COL_START] = r.scol;      hdr_data[HDR_COL_START] = 1'b1;
      hdr[HDR_COL_END]   = ecol;        hdr_data[HDR_COL_END]   = 1'b1;
      hdr[HDR_ROW_CMD]   = CMD_ROW;     hdr_data[HDR_ROW_CMD]   = 1'b0;
      hdr[HDR_ROW_START] = r.srow;      hdr_data[HDR_ROW_START] = 1'b1;
      hdr[HDR_ROW_END]   = erow;        hdr_data[HDR_ROW_END]   = 1'b1;
      hdr[HDR_WRITE_CMD] = CMD_WRITE;   hdr_data[HDR_WRITE_CMD] = 1'b0;
      for (int h = 0; h < HDR_WORDS; h++) begin
        expected_words.push_back('{{8'h00, hdr[h]}, 1'b0, hdr_data[h], k == total - 1});
        k++;
      end
    end
    // pixel lines, leftmost bit first; bits past the field read as clear
    for (int line = 0; line < scale; line++) begin
      for (int j = GW - 1; j >= 0; j--) begin
        px = (j < 8 && r.bits[j]) ? colour : 16'h0000;
        for (int rep = 0; rep < scale; rep++) begin
          expected_words.push_back('{px, 1'b1, 1'b1, k == total - 1});
          k++;
        end
      end
    end
  endtask

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    err_count++;
    if (err_count <= MAX_PRINTS)
      $display("%0t: mismatch on %s at word %0d: got %h, expected %h",
               $time, what, words_checked, got, want);
  endtask

  // input and output transfers, checking and watchdog, all at one edge
  always @(posedge clk) begin : monitor
    glyph_row_t  r;
    panel_word_t e;
    logic        took_in;
    logic        took_out;
    took_in  = rst_n && push && !full;
    took_out = rst_n && pop && !empty;
    if (took_in) begin
      r = '{in_row_bits, in_row_number, in_start_col, in_start_row,
            in_red, in_green, in_blue, in_double_size};
      expand_row(r);
      rows_accepted++;
      if (r.rown == 0) rows_header++;
      if (r.dbl) rows_double++;
    end
    if (took_out) begin
      if (expected_words.size() == 0) begin
        report_mismatch("unexpected word", out_word, 16'h0000);
      end else begin
        e = expected_words.pop_front();
        if (out_word !== e.word) report_mismatch("word", out_word, e.word);
        if (out_is_pixel !== e.is_pixel)
          report_mismatch("is_pixel", 16'(out_is_pixel), 16'(e.is_pixel));
        if (out_is_data !== e.is_data)
          report_mismatch("is_data", 16'(out_is_data), 16'(e.is_data));
        if (out_last !== e.last)
          report_mismatch("last", 16'(out_last), 16'(e.last));
      end
      words_checked++;
    end
    if (!rst_n || took_in || took_out) idle_run = 0;
    else idle_run++;
    if (idle_run >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no transfer for %0d cycles, %0d words outstanding",
               idle_run, expected_words.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // receiver: stall pattern changes per segment of random length; long hold on request
  always @(posedge clk) begin : receiver
    static int       hold_left = 0;
    static int       seg_left = 0;
    static int       phase = 0;
    static rx_mode_t mode = RX_FULL_RATE;
    if (hold_req) hold_left = HOLD_LEN;
    if (hold_left > 0) begin
      pop <= 1'b0;
      hold_left--;
    end else begin
      if (seg_left == 0) begin
        mode     = rx_mode_t'($urandom_range(0, 2));
        seg_left = $urandom_range(4, 64);
      end
      seg_left--;
      phase++;
      case (mode)
        RX_FULL_RATE: pop <= 1'b1;
        RX_RANDOM:    pop <= ($urandom_range(0, 9) < 7);
        default:      pop <= (phase % 3 == 0);
      endcase
    end
  end

  // offer one row and wait for its transfer; push is left high
  task automatic send_row(input glyph_row_t r);
    push           <= 1'b1;
    in_row_bits    <= r.bits;
    in_row_number  <= r.rown;
    in_start_col   <= r.scol;
    in_start_row   <= r.srow;
    in_red         <= r.red;
    in_green       <= r.green;
    in_blue        <= r.blue;
    in_double_size <= r.dbl;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  task automatic idle_for(input int n);
    if (n > 0) begin
      push <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // bursts of random length with random gaps; some gaps are zero
  task automatic send_bursty(input glyph_row_t r);
    if (burst_left == 0) begin
      idle_for(($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 20));
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    send_row(r);
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
  endtask

  function automatic glyph_row_t random_row();
    glyph_row_t r;
    r = glyph_row_t'({$urandom, $urandom});
    case ($urandom_range(0, 7))
      0: r.bits = 8'h00;
      1: r.bits = 8'hFF;
      default: ;
    endcase
    return r;
  endfunction

  // window set-up at the corners, including wrap of the end coordinates
  task automatic test_header_extremes();
    send_row('{8'hFF, 4'd0, 8'd0, 8'd0, 5'd31, 6'd63, 5'd31, 1'b0});
    send_row('{8'h00, 4'd0, 8'd0, 8'd0, 5'd0, 6'd0, 5'd0, 1'b0});
    send_row('{8'h81, 4'd0, 8'd255, 8'd255, 5'd31, 6'd0, 5'd31, 1'b1});
    send_row('{8'h3C, 4'd0, 8'd250, 8'd245, 5'd1, 6'd2, 5'd3, 1'b0});
    send_row('{8'hC3, 4'd0, 8'd241, 8'd225, 5'd16, 6'd32, 5'd16, 1'b1});
    send_row('{8'h7E, 4'd0, 8'd248, 8'd240, 5'd10, 6'd20, 5'd5, 1'b0});
    send_row('{8'hE7, 4'd0, 8'd240, 8'd224, 5'd7, 6'd9, 5'd21, 1'b1});
    send_row('{8'h18, 4'd0, 8'd249, 8'd241, 5'd30, 6'd1, 5'd2, 1'b0});
    wait_drained();
  endtask

  // pixel bit order and each colour channel alone, normal size
  task automatic test_pixels_and_colours();
    send_row('{8'h80, 4'd1, 8'd10, 8'd20, 5'd31, 6'd0, 5'd0, 1'b0});
    send_row('{8'h01, 4'd2, 8'd10, 8'd20, 5'd0, 6'd63, 5'd0, 1'b0});
    send_row('{8'hA5, 4'd3, 8'd10, 8'd20, 5'd0, 6'd0, 5'd31, 1'b0});
    send_row('{8'h5A, 4'd15, 8'd255, 8'd255, 5'd31, 6'd63, 5'd31, 1'b0});
    send_row('{8'hFF, 4'd8, 8'd0, 8'd0, 5'd0, 6'd0, 5'd0, 1'b0});
    idle_for(3);
    send_row('{8'h00, 4'd15, 8'd0, 8'd0, 5'd31, 6'd63, 5'd31, 1'b0});
    wait_drained();
  endtask

  // doubled rows without header, all rows of the glyph in range
  task automatic test_double_size();
    send_row('{8'h5A, 4'd1, 8'd100, 8'd50, 5'd21, 6'd42, 5'd10, 1'b1});
    send_row('{8'hFF, 4'd15, 8'd0, 8'd0, 5'd31, 6'd63, 5'd31, 1'b1});
    send_row('{8'h00, 4'd7, 8'd255, 8'd0, 5'd31, 6'd63, 5'd31, 1'b1});
    send_row('{8'h96, 4'd9, 8'd1, 8'd1, 5'd1, 6'd1, 5'd1, 1'b1});
    wait_drained();
  endtask

  // receiver holds off while rows keep coming, so full must stall the sender
  task automatic test_backpressure();
    hold_req <= 1'b1;
    @(posedge clk);
    hold_req <= 1'b0;
    for (int i = 0; i < 16; i++) send_row(random_row());
    wait_drained();
  endtask

  // mostly whole glyphs (rows 0..15, same window and colour), some broken, some noise
  task automatic test_random_stream();
    glyph_row_t base;
    glyph_row_t r;
    int         sent;
    int         first;
    int         stop;
    sent = 0;
    while (sent < RANDOM_ROWS) begin
      if ($urandom_range(0, 9) < 8) begin
        base  = random_row();
        first = ($urandom_range(0, 7) == 0) ? $urandom_range(1, GH - 1) : 0;
        stop  = ($urandom_range(0, 5) == 0) ? $urandom_range(first, GH - 1) : GH - 1;
        for (int row = first; row <= stop; row++) begin
          r      = base;
          r.bits = random_row().bits;
          r.rown = 4'(row);
          send_bursty(r);
          sent++;
        end
      end else begin
        send_bursty(random_row());
        sent++;
      end
      if ($urandom_range(0, 29) == 0) wait_drained();
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_header_extremes();
    test_pixels_and_colours();
    test_double_size();
    test_backpressure();
    test_random_stream();

    // drain, then allow stray words to show up
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d rows (%0d with window set-up, %0d double size), %0d words",
             rows_accepted, rows_header, rows_double, words_checked);
    $display("Included a long receiver hold-off and full drains; %0d mismatches",
             err_count);
    if (err_count == 0 && expected_words.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/grgb_pkg.sv
rtl/core/grgb_front.sv
rtl/core/grgb_queue.sv
rtl/core/grgb_back.sv
rtl/core/glyph_row_to_rgb565_stream_unit.sv
tb/tb_glyph_row_to_rgb565_stream_unit.sv
